FILE: sv/ikc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikc_pkg: shared constants and types of the indexed keystream byte cipher
// widths, finaliser constants, register indexes and page size clamping
// ----------------------------------------------------------------------------
package ikc_pkg;

	localparam int POS_W      = 32;
	localparam int DATA_W     = 8;
	localparam int WORD_W     = 64;
	localparam int LANE_W     = 3;
	localparam int PAGE_W     = 13;
	localparam int REM_W      = 12;
	localparam int QUO_W      = 28;
	localparam int DIV_STAGES = 7;
	localparam int DIV_STEPS  = 4;
	localparam int NUM_STAGES = 15;
	localparam int LANE_SHIFT = 56;
	localparam int IDX_W      = 3;

	localparam logic [WORD_W-1:0] FIN_MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [WORD_W-1:0] FIN_MUL_B = 64'hc4ceb9fe1a85ec53;
	localparam logic [POS_W:0]    POS_BIAS  = 33'h09E3779B9;
	localparam logic [PAGE_W-1:0] PAGE_MIN  = 13'd16;
	localparam logic [PAGE_W-1:0] PAGE_MAX  = 13'd4096;

	typedef enum logic [IDX_W-1:0] {
		REG_SALT      = 3'd0,
		REG_PG_MULT   = 3'd1,
		REG_IDX_MULT  = 3'd2,
		REG_BIAS      = 3'd3,
		REG_KEY_XOR   = 3'd4,
		REG_PER_PAGE  = 3'd5,
		REG_PAGE_SIZE = 3'd6,
		REG_SEAL      = 3'd7
	} reg_idx_t;

	// per-word side data carried along the pipe
	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic [DATA_W-1:0] data;
	} side_t;

	// zero means the largest page, otherwise clamp to the legal range
	function automatic logic [PAGE_W-1:0] clamp_page(input logic [PAGE_W-1:0] p);
		logic [PAGE_W-1:0] r;
		r = p;
		if (p == '0)
			r = PAGE_MAX;
		else if (p < PAGE_MIN)
			r = PAGE_MIN;
		else if (p > PAGE_MAX)
			r = PAGE_MAX;
		return r;
	endfunction

endpackage

FILE: sv/ikc_mul64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikc_mul64: two stage 64 x 64 multiplier, low 64 bits of the product
// three 32 x 32 partial products, then one sum
// ----------------------------------------------------------------------------
module ikc_mul64 (
	input  logic                        clk,
	input  logic [1:0]                  en,   // bit 0 loads partials, bit 1 loads sum
	input  logic [ikc_pkg::WORD_W-1:0]  a,
	input  logic [ikc_pkg::WORD_W-1:0]  b,
	output logic [ikc_pkg::WORD_W-1:0]  p
);
	import ikc_pkg::*;

	logic [WORD_W-1:0]   lo_s1;
	logic [WORD_W/2-1:0] mid_a_s1;
	logic [WORD_W/2-1:0] mid_b_s1;
	logic [WORD_W-1:0]   p_s2;

	// high x high falls out of the low 64 bits
	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s1    <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
			mid_a_s1 <= a[31:0] * b[63:32];
			mid_b_s1 <= a[63:32] * b[31:0];
		end
		if (en[1])
			p_s2 <= lo_s1 + {mid_a_s1 + mid_b_s1, 32'd0};
	end

	assign p = p_s2;

endmodule

FILE: sv/ikc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikc_div: pipelined restoring divider, position over page size
// four quotient bits per stage; divisor is at least 16 so the top four bits
// of the quotient are zero
// ----------------------------------------------------------------------------
module ikc_div (
	input  logic                              clk,
	input  logic [ikc_pkg::DIV_STAGES-1:0]    en,
	input  logic [ikc_pkg::POS_W-1:0]         pos,
	input  logic [ikc_pkg::PAGE_W-1:0]        divisor,
	output logic [ikc_pkg::QUO_W-1:0]         quo
);
	import ikc_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] z;   // dividend bits still to go, quotient shifted in below
	} div_t;

	function automatic div_t div_steps(input div_t st_in, input logic [PAGE_W-1:0] d);
		div_t             st;
		logic [PAGE_W-1:0] r;
		st = st_in;
		for (int k = 0; k < DIV_STEPS; k++) begin
			r    = {st.rem, st.z[QUO_W-1]};
			st.z = {st.z[QUO_W-2:0], 1'b0};
			if (r >= d) begin
				r       = r - d;
				st.z[0] = 1'b1;
			end
			st.rem = r[REM_W-1:0];
		end
		return st;
	endfunction

	div_t st_s [DIV_STAGES];
	div_t st_init;

	assign st_init.rem = {{(REM_W-(POS_W-QUO_W)){1'b0}}, pos[POS_W-1:QUO_W]};
	assign st_init.z   = pos[QUO_W-1:0];

	always_ff @(posedge clk) begin
		if (en[0])
			st_s[0] <= div_steps(st_init, divisor);
	end

	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[j])
				st_s[j] <= div_steps(st_s[j-1], divisor);
		end
	end

	assign quo = st_s[DIV_STAGES-1].z;

endmodule

FILE: sv/indexed_keystream_byte_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_keystream_byte_cipher_top: position keyed byte xor cipher
// throughput one word per cycle while the output is not stalled; the page
// divider (7 stages) and three of the four two stage 64 bit multipliers set
// the depth; a stalled output holds the valid stages back to the nearest
// bubble, earlier bubbles still fill
// arst_n low empties the pipe and restores the register reset values;
// no clearing pass, the block takes words from the first cycle after reset
// ----------------------------------------------------------------------------
module indexed_keystream_byte_cipher_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [39:0]                      s_tdata,   // [31:0] position, [39:32] data_in
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // [7:0] data_out
	// configuration writes
	input  logic                             cfg_wen,
	input  logic [ikc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ikc_pkg::WORD_W-1:0]       cfg_data
);
	import ikc_pkg::*;

	// configuration registers
	logic [WORD_W-1:0] salt_q;
	logic [WORD_W-1:0] pg_mult_q;
	logic [WORD_W-1:0] idx_mult_q;
	logic [WORD_W-1:0] bias_q;
	logic [DATA_W-1:0] key_xor_q;
	logic              per_page_q;
	logic [PAGE_W-1:0] page_size_q;   // stored already clamped
	logic [WORD_W-1:0] seal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q      <= '0;
			pg_mult_q   <= 64'd1;
			idx_mult_q  <= 64'd1;
			bias_q      <= '0;
			key_xor_q   <= '0;
			per_page_q  <= 1'b0;
			page_size_q <= PAGE_MAX;
			seal_q      <= '0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_SALT:      salt_q      <= cfg_data;
				REG_PG_MULT:   pg_mult_q   <= cfg_data;
				REG_IDX_MULT:  idx_mult_q  <= cfg_data;
				REG_BIAS:      bias_q      <= cfg_data;
				REG_KEY_XOR:   key_xor_q   <= cfg_data[DATA_W-1:0];
				REG_PER_PAGE:  per_page_q  <= cfg_data[0];
				REG_PAGE_SIZE: page_size_q <= clamp_page(cfg_data[PAGE_W-1:0]);
				REG_SEAL:      seal_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: a stage loads when it is empty or the next one loads,
	// so bubbles collapse even while the output word waits
	logic [NUM_STAGES:1] vld;
	logic [NUM_STAGES:1] en;

	always_comb begin
		en[NUM_STAGES] = !vld[NUM_STAGES] || m_tready;
		for (int k = NUM_STAGES - 1; k >= 1; k--)
			en[k] = !vld[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1])
				vld[1] <= s_tvalid;
			for (int k = 2; k <= NUM_STAGES; k++)
				if (en[k])
					vld[k] <= vld[k-1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld[NUM_STAGES];

	// unpack the input word
	logic [POS_W-1:0]  in_pos;
	logic [DATA_W-1:0] in_data;
	assign in_pos  = s_tdata[POS_W-1:0];
	assign in_data = s_tdata[POS_W+DATA_W-1:POS_W];

	// lane and data byte ride along to the last stage
	side_t side_s [1:NUM_STAGES-1];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s[1].lane <= in_pos[LANE_W-1:0];
			side_s[1].data <= in_data;
		end
		for (int k = 2; k < NUM_STAGES; k++)
			if (en[k])
				side_s[k] <= side_s[k-1];
	end

	// stage 1: position plus golden ratio bias, 33 bits
	logic [POS_W:0] tpos_s1;
	always_ff @(posedge clk) begin
		if (en[1])
			tpos_s1 <= {1'b0, in_pos} + POS_BIAS;
	end

	// stages 2-3: index term, then held until the page term is ready
	logic [WORD_W-1:0] idx_prod;
	logic [WORD_W-1:0] idx_s [4:9];

	ikc_mul64 u_idx_mul (
		.clk (clk),
		.en  ({en[3], en[2]}),
		.a   ({{(WORD_W-POS_W-1){1'b0}}, tpos_s1}),
		.b   (idx_mult_q),
		.p   (idx_prod)
	);

	always_ff @(posedge clk) begin
		if (en[4])
			idx_s[4] <= idx_prod;
		for (int k = 5; k <= 9; k++)
			if (en[k])
				idx_s[k] <= idx_s[k-1];
	end

	// stages 1-7: page number
	logic [QUO_W-1:0] page_s7;

	ikc_div u_div (
		.clk     (clk),
		.en      (en[DIV_STAGES:1]),
		.pos     (in_pos),
		.divisor (page_size_q),
		.quo     (page_s7)
	);

	// stages 8-9: (page + 1) times page multiplier
	logic [WORD_W-1:0] page_prod;

	ikc_mul64 u_pg_mult (
		.clk (clk),
		.en  ({en[9], en[8]}),
		.a   ({{(WORD_W-QUO_W-1){1'b0}}, {1'b0, page_s7} + {{QUO_W{1'b0}}, 1'b1}}),
		.b   (pg_mult_q),
		.p   (page_prod)
	);

	// stage 10: build the pre finaliser word
	logic [WORD_W-1:0] page_term;
	logic [WORD_W-1:0] bias_lane;
	logic [WORD_W-1:0] w_s10;

	assign page_term = per_page_q ? page_prod : pg_mult_q;
	// lane sits in the top byte, so only that byte sees the add
	assign bias_lane = {bias_q[WORD_W-1:LANE_SHIFT]
	                    + {{(WORD_W-LANE_SHIFT-LANE_W){1'b0}}, side_s[9].lane},
	                    bias_q[LANE_SHIFT-1:0]};

	always_ff @(posedge clk) begin
		if (en[10])
			w_s10 <= ((salt_q ^ page_term) + idx_s[9]) ^ bias_lane ^ seal_q;
	end

	// stages 11-14: finaliser, xor-shift folded into each multiplier input
	logic [WORD_W-1:0] fin_a;
	logic [WORD_W-1:0] fin_b;

	ikc_mul64 u_fin_mul_a (
		.clk (clk),
		.en  ({en[12], en[11]}),
		.a   (w_s10 ^ (w_s10 >> 33)),
		.b   (FIN_MUL_A),
		.p   (fin_a)
	);

	ikc_mul64 u_fin_mul_b (
		.clk (clk),
		.en  ({en[14], en[13]}),
		.a   (fin_a ^ (fin_a >> 29)),
		.b   (FIN_MUL_B),
		.p   (fin_b)
	);

	// stage 15: last xor-shift, lane byte select, key and data xor
	logic [WORD_W-1:0] fin_w;
	logic [DATA_W-1:0] key_byte;
	logic [DATA_W-1:0] out_s15;

	assign fin_w    = fin_b ^ (fin_b >> 32);
	assign key_byte = fin_w[{side_s[14].lane, 3'b000} +: DATA_W] ^ key_xor_q;

	always_ff @(posedge clk) begin
		if (en[15])
			out_s15 <= side_s[14].data ^ key_byte;
	end

	assign m_tdata = out_s15;

	// a full pipe with a stalled output takes no input word
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld) && !m_tready |-> !s_tready)
		else $error("input taken while pipe full and stalled");

	// an accepted word lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld[1])
		else $error("accepted word lost at stage 1");

	// a delivered word with nothing behind it leaves the output empty
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		vld[NUM_STAGES] && m_tready && !vld[NUM_STAGES-1] |=> !vld[NUM_STAGES])
		else $error("output word repeated");

	// a stalled middle stage keeps its word
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld[10] && !en[11] |=> vld[10])
		else $error("word dropped in stalled stage");

endmodule

FILE: tb/tb_indexed_keystream_byte_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_keystream_byte_cipher_top: self-checking bench for the cipher
// drives position/byte words over the slave stream, predicts each output
// byte from a local copy of the registers (or takes it from the directed
// table) and compares it on the master stream; directed words first, then
// random phases under varied settings and varied stalls on both streams
// ----------------------------------------------------------------------------
module tb_indexed_keystream_byte_cipher_top;

	import ikc_pkg::*;

	// finaliser and position constants, kept apart from the design's copy
	localparam logic [63:0] MIX_A      = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_B      = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] GOLDEN_POS = 64'h000000009E3779B9;
	localparam int          PIPE_DEPTH = 15;
	localparam int          DRAIN_PAD  = PIPE_DEPTH + 5;
	localparam int          CYCLE_CAP  = 200000;
	localparam int          NUM_PHASES = 8;
	localparam int          PHASE_WORDS = 106;

	// local copy of the register file
	typedef struct packed {
		logic [63:0] salt;
		logic [63:0] pg_mult;
		logic [63:0] idx_mult;
		logic [63:0] bias;
		logic [63:0] seal;
		logic [7:0]  key_xor;
		logic        per_page;
		logic [12:0] page_bytes;
	} cipher_regs_t;

	// one row of the directed table: a register write or a word
	typedef struct packed {
		logic        is_write;
		reg_idx_t    idx;
		logic [63:0] value;
		logic [31:0] pos;
		logic [7:0]  data;
		logic        typed;      // expected byte given by hand
		logic [7:0]  typed_out;
	} step_t;

	localparam int NUM_STEPS = 41;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;    // [31:0] position, [39:32] data_in
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] data_out
	logic        cfg_wen = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;

	cipher_regs_t regs;
	logic [7:0]   cipher_q [$];   // output bytes still owed by the block
	int           err_count = 0;
	int           cycles = 0;
	int           src_idle_pct = 0;
	int           sink_stall_pct = 0;

	step_t directed_steps [NUM_STEPS] = '{
		// reset settings: every lane, both ends of the position and byte
		'{1'b0, REG_SALT, 64'h0, 32'h00000000, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'hFFFFFFFF, 8'hFF, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000001, 8'h5A, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000002, 8'hA5, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000003, 8'h0F, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000004, 8'hF0, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000005, 8'h33, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000006, 8'hCC, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000007, 8'h81, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000FFF, 8'h11, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00001000, 8'h22, 1'b0, 8'h00},
		// page number mixed in: crossing a page boundary
		'{1'b1, REG_PER_PAGE, 64'h1, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000FFF, 8'h11, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00001000, 8'h22, 1'b0, 8'h00},
		// zero page size acts as the largest page
		'{1'b1, REG_PAGE_SIZE, 64'h0, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00001000, 8'h00, 1'b0, 8'h00},
		// page size below the minimum
		'{1'b1, REG_PAGE_SIZE, 64'h5, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h0000000F, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000010, 8'h00, 1'b0, 8'h00},
		// page size above the maximum
		'{1'b1, REG_PAGE_SIZE, 64'h1FFF, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00001000, 8'h3C, 1'b0, 8'h00},
		// over-wide values: only the register's own bits land
		'{1'b1, REG_PAGE_SIZE, 64'hFFFF_FFFF_FFFF_0010, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000020, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_PER_PAGE, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00001000, 8'h77, 1'b0, 8'h00},
		// every wide register at all ones
		'{1'b1, REG_SALT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_PG_MULT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_IDX_MULT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_BIAS, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_SEAL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'hFFFFFFFF, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000000, 8'hFF, 1'b0, 8'h00},
		// all zero: lane 0 words see a zero keystream, the byte passes through
		'{1'b1, REG_SALT, 64'h0, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_PG_MULT, 64'h0, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_IDX_MULT, 64'h0, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_BIAS, 64'h0, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b1, REG_SEAL, 64'h0, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000000, 8'h00, 1'b1, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000008, 8'hC3, 1'b1, 8'hC3},
		// key byte alone, written over-wide
		'{1'b1, REG_KEY_XOR, 64'hFFFF_FFFF_FFFF_FF5A, 32'h0, 8'h00, 1'b0, 8'h00},
		'{1'b0, REG_SALT, 64'h0, 32'h00000010, 8'h00, 1'b1, 8'h5A}
	};

	indexed_keystream_byte_cipher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// page size as the divider sees it
	function automatic logic [12:0] effective_page();
		logic [12:0] pg;
		pg = regs.page_bytes;
		if (pg == 13'd0 || pg > 13'd4096)
			pg = 13'd4096;
		else if (pg < 13'd16)
			pg = 13'd16;
		return pg;
	endfunction

	// keystream byte for this position xored onto the data byte
	function automatic logic [7:0] xor_with_keystream(logic [31:0] pos, logic [7:0] data);
		logic [63:0] pos64;
		logic [63:0] page;
		logic [63:0] page_term;
		logic [63:0] w;
		logic [2:0]  lane;
		logic [7:0]  key;
		pos64 = {32'd0, pos};
		lane = pos[2:0];
		page = pos64 / {51'd0, effective_page()};
		page_term = regs.per_page ? (page + 64'd1) * regs.pg_mult : regs.pg_mult;
		w = regs.salt ^ page_term;
		w = w + (pos64 + GOLDEN_POS) * regs.idx_mult;
		w = w ^ (regs.bias + ({61'd0, lane} << 56));
		w = w ^ regs.seal;
		// 64 bit finaliser
		w = w ^ (w >> 33);
		w = w * MIX_A;
		w = w ^ (w >> 29);
		w = w * MIX_B;
		w = w ^ (w >> 32);
		key = w[lane*8 +: 8] ^ regs.key_xor;
		return data ^ key;
	endfunction

	// positions biased towards page edges, small offsets and the ends
	function automatic logic [31:0] random_position();
		logic [31:0] pg;
		pg = {19'd0, effective_page()};
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 65535);
			2: return pg * $urandom_range(0, 2000) - 32'd1 + $urandom_range(0, 2);
			3: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
			default: return $urandom_range(0, 16 * 300);
		endcase
	endfunction

	function automatic logic [63:0] random_reg_value(reg_idx_t idx);
		if (idx == REG_PAGE_SIZE) begin
			case ($urandom_range(0, 5))
				0: return 64'd0;
				1: return 64'($urandom_range(1, 15));
				2: return 64'd16;
				3: return 64'd4096;
				4: return 64'($urandom_range(17, 4095));
				default: return {$urandom(), $urandom()};
			endcase
		end
		return {$urandom(), $urandom()};
	endfunction

	// called at a falling edge, returns at a falling edge with cfg_wen low
	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_SALT:      regs.salt       = value;
			REG_PG_MULT:   regs.pg_mult    = value;
			REG_IDX_MULT:  regs.idx_mult   = value;
			REG_BIAS:      regs.bias       = value;
			REG_KEY_XOR:   regs.key_xor    = value[7:0];
			REG_PER_PAGE:  regs.per_page   = value[0];
			REG_PAGE_SIZE: regs.page_bytes = value[12:0];
			REG_SEAL:      regs.seal       = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// offer one word, with random gaps before it; the owed byte is queued
	// at the edge where the block takes the word
	task automatic push_word(logic [31:0] pos, logic [7:0] data, logic typed,
			logic [7:0] typed_out);
		logic [7:0] owed;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {data, pos};
		do
			@(posedge clk);
		while (!s_tready);
		owed = typed ? typed_out : xor_with_keystream(pos, data);
		cipher_q.insert(cipher_q.size(), owed);
		@(negedge clk);
	endtask

	// stop sending, wait until every owed byte is back, then let the pipe empty
	task automatic settle(int pad);
		s_tvalid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (pad) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// output checker: each taken word against the oldest owed byte
	always @(posedge clk) begin : out_check
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_q.size() == 0) begin
				$error("data_out: no word expected, actual %02h", m_tdata);
				err_count++;
			end else begin
				want = cipher_q.pop_front();
				if (m_tdata !== want) begin
					$error("data_out mismatch: expected %02h, actual %02h", want, m_tdata);
					err_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		regs.salt       = 64'd0;
		regs.pg_mult    = 64'd1;
		regs.idx_mult   = 64'd1;
		regs.bias       = 64'd0;
		regs.seal       = 64'd0;
		regs.key_xor    = 8'd0;
		regs.per_page   = 1'b0;
		regs.page_bytes = 13'd4096;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling on either side
		for (int i = 0; i < NUM_STEPS; i++) begin
			if (directed_steps[i].is_write) begin
				settle(DRAIN_PAD);
				write_reg(directed_steps[i].idx, directed_steps[i].value);
			end else begin
				push_word(directed_steps[i].pos, directed_steps[i].data,
					directed_steps[i].typed, directed_steps[i].typed_out);
			end
		end

		// random phases, a fresh register setting each time
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle(DRAIN_PAD);
			for (int r = 0; r < 8; r++) begin
				reg_idx_t idx;
				logic [63:0] value;
				idx = reg_idx_t'(r);
				if (ph == 0)
					value = '1;   // everything at its top value
				else if (ph == 1) begin
					// smallest pages, page number mixed in, random page multiplier, index multiplier one, the rest at zero
					case (idx)
						REG_PG_MULT:   value = {$urandom(), $urandom()};
						REG_IDX_MULT:  value = 64'd1;
						REG_PER_PAGE:  value = 64'd1;
						REG_PAGE_SIZE: value = 64'd16;
						default:       value = 64'd0;
					endcase
				end else
					value = random_reg_value(idx);
				write_reg(idx, value);
			end

			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
				default: begin src_idle_pct = 6; sink_stall_pct = 6; end
			endcase

			for (int n = 0; n < PHASE_WORDS; n++) begin
				// halfway through one phase the sender waits for the pipe to empty
				if (ph == 2 && n == PHASE_WORDS / 2)
					settle(0);
				push_word(random_position(), 8'($urandom_range(0, 255)), 1'b0, 8'h00);
			end
		end

		settle(DRAIN_PAD);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
